// File: hw/rtl/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // Decoder modes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_PLAIN = 2'd1;
  localparam logic [1:0] MODE_ESC   = 2'd2;
  localparam logic [1:0] MODE_HEX   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Most results one input byte can cause.
  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } res_ent_t;

  typedef struct packed {
    res_ent_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]       cnt;
  } res_list_t;

  // Returns {valid, value} for an ASCII hex digit of either case.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/json_string_unescape_utf8_top.sv
// The first result of a byte is offered in the cycle after the byte's beat.
// Throughput, set by the result shift buffer: one byte per cycle while each byte
// yields at most one result and the output is not stalled; a byte with more results
// (up to five) stalls input; the next byte is taken as its last result is consumed.
// Reset: synchronous, active low; no string is open and the result buffer is empty.
`timescale 1ns / 1ps

module json_string_unescape_utf8_top
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] first_byte
  input  logic       in_tlast,   // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast   // last_of_run
);

  res_list_t             dec_res;
  res_ent_t [MAX_RES-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  load;

  assign in_tready = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);
  assign load      = in_tvalid && in_tready;

  jsu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .data_byte  (in_tdata),
    .first_byte (in_tuser),
    .final_byte (in_tlast),
    .res        (dec_res)
  );

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = dec_res.ent;
      cnt_nxt = dec_res.cnt;
    end else if (out_tvalid && out_tready) begin
      buf_nxt = {res_ent_t'('0), buf_r[MAX_RES-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = buf_r[0].data;
  assign out_tuser  = buf_r[0].kind;
  assign out_tlast  = (cnt_r == CNT_W'(1));

endmodule

// File: hw/rtl/jsu_decode.sv
// Escape decoder: holds the string state and expands one byte into its result list.
`timescale 1ns / 1ps

module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       final_byte,
  output res_list_t  res
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [11:0] pcp_r, pcp_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];

  logic [4:0]  hv;
  logic [15:0] cp;

  always_comb begin
    res = '0;
    mode_nxt = first_byte ? MODE_PLAIN : mode_r;
    dcnt_nxt = first_byte ? 2'd0 : dcnt_r;
    pcp_nxt  = first_byte ? 12'd0 : pcp_r;
    for (int i = 0; i < 3; i++) begin
      held_nxt[i] = held_r[i];
    end
    hv = hex_val(data_byte);
    cp = {pcp_nxt, hv[3:0]};

    if (mode_nxt != MODE_IDLE) begin
      case (mode_nxt)
        MODE_PLAIN: begin
          if (data_byte == 8'h5C) begin
            mode_nxt = MODE_ESC;
          end else if (data_byte == 8'h22) begin
            res.ent[res.cnt] = '{data: 8'h00, kind: KIND_CLOSE};
            res.cnt = res.cnt + CNT_W'(1);
            mode_nxt = MODE_IDLE;
          end else begin
            res.ent[res.cnt] = '{data: data_byte, kind: KIND_DATA};
            res.cnt = res.cnt + CNT_W'(1);
          end
        end
        MODE_ESC: begin
          mode_nxt = MODE_PLAIN;
          res.cnt = CNT_W'(1);
          case (data_byte)
            8'h6E:   res.ent[0] = '{data: 8'h0A, kind: KIND_DATA};
            8'h72:   res.ent[0] = '{data: 8'h0D, kind: KIND_DATA};
            8'h74:   res.ent[0] = '{data: 8'h09, kind: KIND_DATA};
            8'h75: begin
              mode_nxt = MODE_HEX;
              dcnt_nxt = 2'd0;
              pcp_nxt  = 12'd0;
              res.cnt  = '0;
            end
            default: res.ent[0] = '{data: data_byte, kind: KIND_DATA};
          endcase
        end
        default: begin
          if (!hv[4]) begin
            // Not a hex digit: give back the held digits, then treat the byte as text.
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < dcnt_nxt) begin
                res.ent[res.cnt] = '{data: held_nxt[i], kind: KIND_DATA};
                res.cnt = res.cnt + CNT_W'(1);
              end
            end
            dcnt_nxt = 2'd0;
            pcp_nxt  = 12'd0;
            mode_nxt = MODE_PLAIN;
            if (data_byte == 8'h5C) begin
              mode_nxt = MODE_ESC;
            end else if (data_byte == 8'h22) begin
              res.ent[res.cnt] = '{data: 8'h00, kind: KIND_CLOSE};
              res.cnt = res.cnt + CNT_W'(1);
              mode_nxt = MODE_IDLE;
            end else begin
              res.ent[res.cnt] = '{data: data_byte, kind: KIND_DATA};
              res.cnt = res.cnt + CNT_W'(1);
            end
          end else if (dcnt_nxt == 2'd3) begin
            // Fourth digit completes the code point: encode as UTF-8.
            if (cp < 16'h0080) begin
              res.ent[0] = '{data: cp[7:0], kind: KIND_DATA};
              res.cnt = 3'd1;
            end else if (cp < 16'h0800) begin
              res.ent[0] = '{data: {3'b110, cp[10:6]}, kind: KIND_DATA};
              res.ent[1] = '{data: {2'b10, cp[5:0]}, kind: KIND_DATA};
              res.cnt = 3'd2;
            end else begin
              res.ent[0] = '{data: {4'b1110, cp[15:12]}, kind: KIND_DATA};
              res.ent[1] = '{data: {2'b10, cp[11:6]}, kind: KIND_DATA};
              res.ent[2] = '{data: {2'b10, cp[5:0]}, kind: KIND_DATA};
              res.cnt = 3'd3;
            end
            dcnt_nxt = 2'd0;
            pcp_nxt  = 12'd0;
            mode_nxt = MODE_PLAIN;
          end else begin
            held_nxt[dcnt_nxt] = data_byte;
            pcp_nxt  = {pcp_nxt[7:0], hv[3:0]};
            dcnt_nxt = dcnt_nxt + 2'd1;
          end
        end
      endcase

      if (final_byte) begin
        if (mode_nxt == MODE_HEX) begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < dcnt_nxt) begin
              res.ent[res.cnt] = '{data: held_nxt[i], kind: KIND_DATA};
              res.cnt = res.cnt + CNT_W'(1);
            end
          end
          dcnt_nxt = 2'd0;
          pcp_nxt  = 12'd0;
        end
        if (mode_nxt != MODE_IDLE) begin
          res.ent[res.cnt] = '{data: 8'h00, kind: KIND_END};
          res.cnt = res.cnt + CNT_W'(1);
          mode_nxt = MODE_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      dcnt_r <= 2'd0;
      pcp_r  <= 12'd0;
    end else if (load) begin
      mode_r <= mode_nxt;
      dcnt_r <= dcnt_nxt;
      pcp_r  <= pcp_nxt;
    end
  end

  // Held digit characters are only read below the digit count, so they need no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= held_nxt[i];
      end
    end
  end

endmodule

// File: hw/rtl/jsu_check.sv
// Port-level assertions for the JSON string unescaper, bound to the top level.
`timescale 1ns / 1ps

module jsu_check
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A new byte is never taken while a result waits unconsumed.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken over a pending result");

  // The input only stalls while results are pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tlast || out_tvalid && !out_tready)
    else $error("input stalled with no pending result");

  // Status results carry a zero byte, and the unclosed report ends its run.
  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_CLOSE || out_tuser == KIND_END)
      |-> out_tdata == 8'h00 && (out_tuser == KIND_CLOSE || out_tlast))
    else $error("malformed status result");

endmodule

bind json_string_unescape_utf8_top jsu_check u_jsu_check (.*);
